@@ rtl/core/kcl_pkg.sv @@
`default_nettype none

package kcl_pkg;

    // Key codes with a special meaning
    localparam logic [3:0] KEY_STAR = 4'd14;
    localparam logic [3:0] KEY_HASH = 4'd15;

    // Code loaded at reset
    localparam int RESET_CODE_LEN = 4;
    localparam logic [3:0] RESET_CODE [RESET_CODE_LEN] = '{4'd6, 4'd7, 4'd8, 4'd9};

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_MIN_CODE_LEN = 2'd0;
    localparam logic [1:0] CFG_LOCK_SECOND  = 2'd1;
    localparam logic [1:0] CFG_LOCK_THIRD   = 2'd2;

    localparam logic [3:0]  RST_MIN_CODE_LEN = 4'd4;
    localparam logic [19:0] RST_LOCK_SECOND  = 20'd5000;
    localparam logic [19:0] RST_LOCK_THIRD   = 20'd30000;

    // Result events
    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_STORED    = 4'd1,
        EV_FULL      = 4'd2,
        EV_LOCKDROP  = 4'd3,
        EV_OK        = 4'd4,
        EV_WRONG     = 4'd5,
        EV_CHANGE    = 4'd6,
        EV_CANCEL    = 4'd7,
        EV_CUROK     = 4'd8,
        EV_CURWRONG  = 4'd9,
        EV_SAVED     = 4'd10,
        EV_SHORT     = 4'd11,
        EV_UNLOCK    = 4'd12
    } ev_t;

    // Entry phase, one-hot
    typedef enum logic [2:0] {
        PH_NORMAL  = 3'b001,
        PH_CURRENT = 3'b010,
        PH_NEW     = 3'b100
    } phase_t;

    localparam logic [1:0] PHASE_CODE_NORMAL  = 2'd0;
    localparam logic [1:0] PHASE_CODE_CURRENT = 2'd1;
    localparam logic [1:0] PHASE_CODE_NEW     = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [3:0] key_code;
        logic       door_busy;
    } kcl_item_t;

    typedef struct packed {
        logic [3:0]  min_code_len;
        logic [19:0] lock_ms_second_fail;
        logic [19:0] lock_ms_third_fail;
    } kcl_cfg_t;

    typedef struct packed {
        ev_t        event_res;
        logic       open_door;
        logic [1:0] phase;
        logic [3:0] entry_length;
        logic [1:0] failed_count;
        logic       locked_out;
    } kcl_result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_CURRENT: code = PHASE_CODE_CURRENT;
            PH_NEW:     code = PHASE_CODE_NEW;
            default:    code = PHASE_CODE_NORMAL;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/keypad_code_lock_top.sv @@
// Keypad code lock.
// Input channel (s_valid/s_ready): one transaction is a key press (s_mode 0,
// s_key_code, s_door_busy) or a one millisecond tick (s_mode 1).
// Result channel (m_valid/m_ready): exactly one result per input transaction,
// in order: event code, door open pulse, entry phase, entry length, failure
// count and lockout flag, all taken after the update.
// Configuration channel (cfg_valid/cfg_ready, always ready): cfg_index 0 sets
// the minimum new code length, 1 and 2 set the lockout lengths in ticks;
// write only while no transaction is in flight.
// Path: an input register, then the lock logic, then the result register.
// Throughput: one transaction per cycle unless the receiver stalls; the lock
// state updates as each transaction advances, so each transaction sees the
// state left by the one before.
// Reset (aresetn low, synchronous): stored code 6789, entry empty, no
// failures, no lockout, configuration at its defaults, both stages empty.
// Receiver stall: the result register holds; one more transaction waits in
// the input register, after which s_ready drops until m_ready returns.
`default_nettype none

module keypad_code_lock_top
    import kcl_pkg::*;
#(
    parameter int MAX_CODE_LEN = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [3:0]  s_key_code,
    input  wire logic        s_door_busy,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_event_res,
    output logic             m_open_door,
    output logic [1:0]       m_phase,
    output logic [3:0]       m_entry_length,
    output logic [1:0]       m_failed_count,
    output logic             m_locked_out,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_wdata
);

    logic        in_valid_reg;
    kcl_item_t   in_item_reg;
    logic        out_valid_reg;
    kcl_result_t out_res_reg;
    kcl_cfg_t    cfg_reg;
    kcl_result_t step_res;
    logic        advance;

    // Move the held transaction into the result register when there is room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{mode: s_mode, key_code: s_key_code, door_busy: s_door_busy};
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_code_len        <= RST_MIN_CODE_LEN;
            cfg_reg.lock_ms_second_fail <= RST_LOCK_SECOND;
            cfg_reg.lock_ms_third_fail  <= RST_LOCK_THIRD;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MIN_CODE_LEN: cfg_reg.min_code_len        <= cfg_wdata[3:0];
                CFG_LOCK_SECOND:  cfg_reg.lock_ms_second_fail <= cfg_wdata;
                CFG_LOCK_THIRD:   cfg_reg.lock_ms_third_fail  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    kcl_engine #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (step_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_event_res    = out_res_reg.event_res;
    assign m_open_door    = out_res_reg.open_door;
    assign m_phase        = out_res_reg.phase;
    assign m_entry_length = out_res_reg.entry_length;
    assign m_failed_count = out_res_reg.failed_count;
    assign m_locked_out   = out_res_reg.locked_out;

    // The door only opens on a matching code
    a_open_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_open_door) |-> (m_event_res == EV_OK))
        else $error("door opened without a matching code");

    // Unlock ends the lockout
    a_unlock_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_res == EV_UNLOCK)) |-> !m_locked_out)
        else $error("lockout still set on unlock");

    // A processed transaction always shows up as a result
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed transaction lost");

    // Input stalls only behind a full result stage
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without back pressure");

endmodule

`default_nettype wire

@@ rtl/core/kcl_engine.sv @@
`default_nettype none

module kcl_engine
    import kcl_pkg::*;
#(
    parameter int MAX_CODE_LEN = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step_en,
    input  wire kcl_item_t   item,
    input  wire kcl_cfg_t    cfg,
    output kcl_result_t      result
);

    localparam int CW = $clog2(MAX_CODE_LEN + 1);
    localparam int IW = $clog2(MAX_CODE_LEN);

    // Lock state
    logic [3:0]    stored_code_reg [MAX_CODE_LEN];
    logic [3:0]    stored_code_next [MAX_CODE_LEN];
    logic [CW-1:0] stored_len_reg, stored_len_next;
    logic [3:0]    entry_reg [MAX_CODE_LEN];
    logic [3:0]    entry_next [MAX_CODE_LEN];
    logic [CW-1:0] count_reg, count_next;
    phase_t        phase_reg, phase_next;
    logic [1:0]    fail_reg, fail_next;
    logic [19:0]   remain_reg, remain_next;

    logic          match;
    logic          len_ok;
    logic [1:0]    fail_inc;
    logic [CW+3:0] count_wide;
    ev_t           ev;
    logic          open_door;

    // Compare entry with the stored code
    always_comb begin
        match = (count_reg == stored_len_reg);
        for (int i = 0; i < MAX_CODE_LEN; i++) begin
            if ((CW'(i) < count_reg) && (entry_reg[i] != stored_code_reg[i])) begin
                match = 1'b0;
            end
        end
    end

    assign len_ok   = ({4'b0, count_reg} >= {{CW{1'b0}}, cfg.min_code_len});
    assign fail_inc = (fail_reg == 2'd3) ? 2'd3 : fail_reg + 2'd1;

    // Next state for one transaction
    always_comb begin
        stored_code_next = stored_code_reg;
        stored_len_next  = stored_len_reg;
        entry_next       = entry_reg;
        count_next       = count_reg;
        phase_next       = phase_reg;
        fail_next        = fail_reg;
        remain_next      = remain_reg;
        ev               = EV_NONE;
        open_door        = 1'b0;

        if (item.mode) begin
            if (remain_reg != 20'd0) begin
                remain_next = remain_reg - 20'd1;
                if (remain_reg == 20'd1) begin
                    ev = EV_UNLOCK;
                end
            end
        end else if (remain_reg != 20'd0) begin
            ev = EV_LOCKDROP;
        end else if (item.key_code == KEY_STAR) begin
            // Star opens a code change, or cancels one in progress
            for (int i = 0; i < MAX_CODE_LEN; i++) entry_next[i] = 4'd0;
            count_next = '0;
            if (phase_reg == PH_NORMAL) begin
                phase_next = PH_CURRENT;
                ev         = EV_CHANGE;
            end else begin
                phase_next = PH_NORMAL;
                ev         = EV_CANCEL;
            end
        end else if (item.key_code == KEY_HASH) begin
            for (int i = 0; i < MAX_CODE_LEN; i++) entry_next[i] = 4'd0;
            count_next = '0;
            case (phase_reg)
                PH_CURRENT: begin
                    if (match) begin
                        phase_next = PH_NEW;
                        ev         = EV_CUROK;
                    end else begin
                        ev = EV_CURWRONG;
                    end
                end
                PH_NEW: begin
                    if (len_ok) begin
                        stored_code_next = entry_reg;
                        stored_len_next  = count_reg;
                        phase_next       = PH_NORMAL;
                        ev               = EV_SAVED;
                    end else begin
                        ev = EV_SHORT;
                    end
                end
                default: begin
                    phase_next = PH_NORMAL;
                    if (match) begin
                        ev        = EV_OK;
                        open_door = ~item.door_busy;
                        fail_next = 2'd0;
                    end else begin
                        ev        = EV_WRONG;
                        fail_next = fail_inc;
                        if (fail_inc == 2'd2) begin
                            remain_next = cfg.lock_ms_second_fail;
                        end else if (fail_inc == 2'd3) begin
                            remain_next = cfg.lock_ms_third_fail;
                        end
                    end
                end
            endcase
        end else begin
            // Store the key, drop it when the buffer is full
            if (count_reg == CW'(MAX_CODE_LEN)) begin
                ev = EV_FULL;
            end else begin
                entry_next[count_reg[IW-1:0]] = item.key_code;
                count_next                    = count_reg + CW'(1);
                ev                            = EV_STORED;
            end
        end
    end

    // Update state on each processed transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RESET_CODE_LEN; i++) begin
                stored_code_reg[i] <= RESET_CODE[i];
            end
            for (int i = RESET_CODE_LEN; i < MAX_CODE_LEN; i++) begin
                stored_code_reg[i] <= 4'd0;
            end
            for (int i = 0; i < MAX_CODE_LEN; i++) begin
                entry_reg[i] <= 4'd0;
            end
            stored_len_reg <= CW'(RESET_CODE_LEN);
            count_reg      <= '0;
            phase_reg      <= PH_NORMAL;
            fail_reg       <= 2'd0;
            remain_reg     <= 20'd0;
        end else if (step_en) begin
            stored_code_reg <= stored_code_next;
            stored_len_reg  <= stored_len_next;
            entry_reg       <= entry_next;
            count_reg       <= count_next;
            phase_reg       <= phase_next;
            fail_reg        <= fail_next;
            remain_reg      <= remain_next;
        end
    end

    assign count_wide = {4'b0, count_next};

    // Result fields reflect the state after the update
    always_comb begin
        result.event_res    = ev;
        result.open_door    = open_door;
        result.phase        = phase_code(phase_next);
        result.entry_length = count_wide[3:0];
        result.failed_count = fail_next;
        result.locked_out   = (remain_next != 20'd0);
    end

endmodule

`default_nettype wire

@@ dv/keypad_code_lock_top_tb.sv @@
`timescale 1ns / 100ps

module keypad_code_lock_top_tb;
    import kcl_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = 1'b0;
    logic [3:0]  s_key_code = '0;
    logic        s_door_busy = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_event_res;
    logic        m_open_door;
    logic [1:0]  m_phase;
    logic [3:0]  m_entry_length;
    logic [1:0]  m_failed_count;
    logic        m_locked_out;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [19:0] cfg_wdata = '0;

    keypad_code_lock_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_key_code     (s_key_code),
        .s_door_busy    (s_door_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_open_door    (m_open_door),
        .m_phase        (m_phase),
        .m_entry_length (m_entry_length),
        .m_failed_count (m_failed_count),
        .m_locked_out   (m_locked_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Lock state as the testbench sees it, advanced at each accepted key or tick
    logic [3:0]  saved_code [8];
    int          saved_len;
    logic [3:0]  entry_buf [8];
    int          entry_cnt;
    logic [1:0]  ph;
    int          fails;
    logic [19:0] lock_left;
    logic [3:0]  min_len;
    logic [19:0] lock2_ms;
    logic [19:0] lock3_ms;

    kcl_item_t   key_items_q [$];
    kcl_result_t lock_results_q [$];

    bit          no_idle = 1'b0;
    bit          hold_go = 1'b0;
    logic        hold_off = 1'b0;
    int          err_cnt = 0;
    int          cyc = 0;
    int          sent_items = 0;
    int          checked = 0;
    int          opens = 0;
    int          cfg_writes = 0;
    int          ev_seen [16];

    function automatic void clear_entry();
        foreach (entry_buf[i]) entry_buf[i] = '0;
        entry_cnt = 0;
    endfunction

    function automatic bit code_matches();
        if (entry_cnt != saved_len) return 1'b0;
        for (int i = 0; i < entry_cnt; i++)
            if (entry_buf[i] != saved_code[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic ev_t entry_add(input logic [3:0] k);
        if (entry_cnt >= 8) return EV_FULL;
        entry_buf[entry_cnt] = k;
        entry_cnt++;
        return EV_STORED;
    endfunction

    task automatic lock_reset();
        foreach (saved_code[i]) saved_code[i] = '0;
        for (int i = 0; i < RESET_CODE_LEN; i++) saved_code[i] = RESET_CODE[i];
        saved_len = RESET_CODE_LEN;
        clear_entry();
        ph = PHASE_CODE_NORMAL;
        fails = 0;
        lock_left = '0;
        min_len = RST_MIN_CODE_LEN;
        lock2_ms = RST_LOCK_SECOND;
        lock3_ms = RST_LOCK_THIRD;
    endtask

    // Work out the result of one key or tick and advance the lock state
    task automatic lock_step(input kcl_item_t it, output kcl_result_t r);
        ev_t  ev;
        logic opened;
        ev = EV_NONE;
        opened = 1'b0;
        if (it.mode) begin
            if (lock_left != 0) begin
                lock_left--;
                if (lock_left == 0) ev = EV_UNLOCK;
            end
        end else if (lock_left != 0) begin
            ev = EV_LOCKDROP;
        end else if (ph != PHASE_CODE_NORMAL) begin
            if (it.key_code == KEY_STAR) begin
                clear_entry();
                ph = PHASE_CODE_NORMAL;
                ev = EV_CANCEL;
            end else if (it.key_code == KEY_HASH) begin
                if (ph == PHASE_CODE_CURRENT) begin
                    if (code_matches()) begin
                        ph = PHASE_CODE_NEW;
                        ev = EV_CUROK;
                    end else begin
                        ev = EV_CURWRONG;
                    end
                end else if (entry_cnt >= min_len) begin
                    saved_code = entry_buf;
                    saved_len = entry_cnt;
                    ph = PHASE_CODE_NORMAL;
                    ev = EV_SAVED;
                end else begin
                    ev = EV_SHORT;
                end
                clear_entry();
            end else begin
                ev = entry_add(it.key_code);
            end
        end else if (it.key_code == KEY_STAR) begin
            clear_entry();
            ph = PHASE_CODE_CURRENT;
            ev = EV_CHANGE;
        end else if (it.key_code == KEY_HASH) begin
            if (code_matches()) begin
                ev = EV_OK;
                opened = !it.door_busy;
                fails = 0;
            end else begin
                ev = EV_WRONG;
                if (fails < 3) fails++;
                if (fails == 2) lock_left = lock2_ms;
                else if (fails >= 3) lock_left = lock3_ms;
            end
            clear_entry();
        end else begin
            ev = entry_add(it.key_code);
        end
        r.event_res    = ev;
        r.open_door    = opened;
        r.phase        = ph;
        r.entry_length = 4'(entry_cnt);
        r.failed_count = 2'(fails);
        r.locked_out   = (lock_left != 0);
    endtask

    // Driver: offer queued keys and ticks, predict each accepted transaction
    bit          offer;
    int          send_gap = 0;
    kcl_item_t   cur_item;
    kcl_result_t next_res;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                lock_step(cur_item, next_res);
                lock_results_q.push_back(next_res);
                offer = 1'b0;
                send_gap = no_idle ? 0 : $urandom_range(0, 12);
            end else if (!offer && send_gap > 0) begin
                send_gap--;
            end
            if (!offer && send_gap == 0 && key_items_q.size() != 0) begin
                cur_item = key_items_q.pop_front();
                s_mode <= cur_item.mode;
                s_key_code <= cur_item.key_code;
                s_door_busy <= cur_item.door_busy;
                offer = 1'b1;
            end
            s_valid <= offer;
        end
    end

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // Monitor: compare each accepted result with the oldest prediction
    int          stall_left = 0;
    kcl_result_t want_res;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (lock_results_q.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    err_cnt++;
                end else begin
                    want_res = lock_results_q.pop_front();
                    check_field("event_res", want_res.event_res, m_event_res);
                    check_field("open_door", want_res.open_door, m_open_door);
                    check_field("phase", want_res.phase, m_phase);
                    check_field("entry_length", want_res.entry_length, m_entry_length);
                    check_field("failed_count", want_res.failed_count, m_failed_count);
                    check_field("locked_out", want_res.locked_out, m_locked_out);
                end
                checked++;
                if (m_open_door === 1'b1) opens++;
                if (!$isunknown(m_event_res)) ev_seen[m_event_res]++;
                stall_left = no_idle ? 0 : $urandom_range(0, 12);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_ready <= (stall_left == 0) && !hold_off;
        end
    end

    // Long receiver hold-off so the block fills up and drops s_ready
    initial begin
        wait (hold_go);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_key(input logic [3:0] k, input logic busy);
        kcl_item_t it;
        it.mode = 1'b0;
        it.key_code = k;
        it.door_busy = busy;
        key_items_q.push_back(it);
        sent_items++;
    endtask

    task automatic send_tick();
        kcl_item_t it;
        it.mode = 1'b1;
        it.key_code = 4'($urandom_range(0, 15));
        it.door_busy = 1'($urandom_range(0, 1));
        key_items_q.push_back(it);
        sent_items++;
    endtask

    task automatic send_code(input logic [3:0] keys [$]);
        foreach (keys[i]) send_key(keys[i], 1'($urandom_range(0, 1)));
    endtask

    task automatic send_random_keys(input int n);
        for (int i = 0; i < n; i++)
            send_key(4'($urandom_range(0, 13)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_saved_code();
        for (int i = 0; i < saved_len; i++)
            send_key(saved_code[i], 1'($urandom_range(0, 1)));
    endtask

    // One sequence of keys and ticks, chosen from the current lock state
    task automatic send_random_sequence();
        int   sel;
        int   n;
        logic busy;
        sel = $urandom_range(0, 99);
        busy = 1'($urandom_range(0, 1));
        if (lock_left != 0) begin
            // count the lockout down, with stray keys mixed in
            n = (lock_left > 40) ? 40 : int'(lock_left);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 4) == 0)
                    send_key(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                send_tick();
            end
        end else if (sel < 30) begin
            // open attempt with the stored code
            if (ph != PHASE_CODE_NORMAL) send_key(KEY_STAR, busy);
            send_saved_code();
            send_key(KEY_HASH, busy);
        end else if (sel < 45) begin
            // guess
            send_random_keys($urandom_range(0, 10));
            send_key(KEY_HASH, busy);
        end else if (sel < 75) begin
            // code change: verify, then enter the new code
            if (ph != PHASE_CODE_NORMAL) send_key(KEY_STAR, busy);
            send_key(KEY_STAR, busy);
            if ($urandom_range(0, 4) != 0) send_saved_code();
            else send_random_keys($urandom_range(0, 9));
            send_key(KEY_HASH, busy);
            send_random_keys(($urandom_range(0, 7) == 0) ? $urandom_range(9, 11)
                                                         : $urandom_range(0, 8));
            send_key(($urandom_range(0, 9) == 0) ? KEY_STAR : KEY_HASH, busy);
        end else if (sel < 90) begin
            // noise
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0) send_tick();
                else send_key(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            end
        end else begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) send_tick();
        end
    endtask

    task automatic wait_drained(input bit results_too);
        do @(negedge aclk);
        while (key_items_q.size() != 0 || s_valid ||
               (results_too && lock_results_q.size() != 0));
    endtask

    task automatic run_random(input int n);
        int start;
        start = sent_items;
        while (sent_items - start < n) begin
            send_random_sequence();
            wait_drained(1'b0);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_CODE_LEN: min_len = val[3:0];
            CFG_LOCK_SECOND:  lock2_ms = val;
            CFG_LOCK_THIRD:   lock3_ms = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Wait for the block to go quiet, then load a new setting
    task automatic configure(input logic [3:0] min_v, input logic [19:0] l2,
                             input logic [19:0] l3);
        wait_drained(1'b1);
        repeat (3) @(posedge aclk);
        write_reg(CFG_MIN_CODE_LEN, {16'($urandom), min_v});
        write_reg(CFG_LOCK_SECOND, l2);
        write_reg(CFG_LOCK_THIRD, l3);
        @(negedge aclk);
    endtask

    initial begin
        foreach (ev_seen[i]) ev_seen[i] = 0;
        lock_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: tick while unlocked, opens (free and busy door),
        // a single failure, a full code change that ends in a too short code
        send_tick();
        send_code('{4'd6, 4'd7, 4'd8, 4'd9});
        send_key(KEY_HASH, 1'b0);
        send_code('{4'd1, 4'd2});
        send_key(KEY_HASH, 1'b0);
        send_code('{4'd6, 4'd7, 4'd8, 4'd9});
        send_key(KEY_HASH, 1'b1);
        send_key(KEY_STAR, 1'b0);
        send_key(4'd1, 1'b0);
        send_key(KEY_HASH, 1'b0);
        send_code('{4'd6, 4'd7, 4'd8, 4'd9});
        send_key(KEY_HASH, 1'b0);
        send_code('{4'd12, 4'd13});
        send_key(KEY_HASH, 1'b0);
        send_key(KEY_STAR, 1'b1);

        // No minimum and no lockouts: save an empty code, open with it,
        // then save a full length code with one key dropped
        configure(4'd0, 20'd0, 20'd0);
        send_key(KEY_STAR, 1'b0);
        send_code('{4'd6, 4'd7, 4'd8, 4'd9});
        send_key(KEY_HASH, 1'b0);
        send_key(KEY_HASH, 1'b0);
        send_key(KEY_HASH, 1'b0);
        send_key(KEY_STAR, 1'b0);
        send_key(KEY_HASH, 1'b0);
        send_code('{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd10, 4'd11, 4'd8, 4'd9});
        send_key(KEY_HASH, 1'b1);
        wait_drained(1'b0);
        run_random(300);

        // Full length minimum, short lockouts, long receiver hold-off
        configure(4'd8, 20'd3, 20'd9);
        hold_go = 1'b1;
        run_random(600);

        // Minimum above the buffer size, back to back traffic
        configure(4'd15, 20'd1, 20'd20);
        no_idle = 1'b1;
        run_random(300);
        no_idle = 1'b0;

        configure(4'($urandom_range(1, 8)), 20'($urandom_range(0, 30)),
                  20'($urandom_range(0, 60)));
        run_random(700);

        // Longest lockouts: fail until locked, then poke at the locked block
        configure(4'd4, 20'hFFFFF, 20'hFFFFF);
        run_random(100);
        for (int i = 0; i < 10 && lock_left == 0; i++) begin
            if (ph != PHASE_CODE_NORMAL) send_key(KEY_STAR, 1'b0);
            if (saved_len == 0) send_key(4'd5, 1'b0);
            send_key(KEY_HASH, 1'b0);
            wait_drained(1'b0);
        end
        for (int i = 0; i < 30; i++) begin
            if ($urandom_range(0, 1) != 0) send_tick();
            else send_key(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end

        wait_drained(1'b1);
        repeat (5) @(posedge aclk);
        if (lock_results_q.size() != 0) begin
            $error("%0d predicted results never arrived", lock_results_q.size());
            err_cnt++;
        end
        $display("Checked %0d transactions over %0d register writes: %0d door opens, %0d saved",
                 checked, cfg_writes, opens, ev_seen[EV_SAVED]);
        $display("Wrong codes %0d, lockouts released %0d, keys dropped locked %0d / full %0d",
                 ev_seen[EV_WRONG], ev_seen[EV_UNLOCK], ev_seen[EV_LOCKDROP], ev_seen[EV_FULL]);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/kcl_pkg.sv
rtl/core/kcl_engine.sv
rtl/core/keypad_code_lock_top.sv
dv/keypad_code_lock_top_tb.sv
